// File: sv/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

    // Fixed field widths, class count and result buffer depth
    localparam int SPAN_W     = 32;
    localparam int SUM_W      = 40;
    localparam int NUM_CLS    = 3;
    localparam int CLS_W      = 2;
    localparam int FIFO_DEPTH = 4;

    localparam logic [SPAN_W-1:0] SPAN_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    // Span kind codes as they appear on the result beat
    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PERIOD = 2'd1,
        KIND_HIGH   = 2'd2,
        KIND_LOW    = 2'd3
    } t_kind;

    // One span operation handed from the issue stage to the statistics stage
    typedef struct packed {
        t_kind             kind;
        logic [SPAN_W-1:0] span;
        logic              last;
    } t_op;

    // Map a span kind to its statistics entry (period 0, high 1, low 2)
    function automatic logic [CLS_W-1:0] cls_of(input t_kind kind);
        logic [CLS_W-1:0] k;
        k = kind;
        return k - CLS_W'(1);
    endfunction

endpackage

// File: sv/pts_issue.sv
`timescale 1ns / 1ps
module pts_issue #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_level,
    input  logic [TIME_WIDTH-1:0]  i_timestamp_us,
    input  logic                   i_credit_ok,
    output logic                   o_op_valid,
    output pts_pkg::t_op           o_op,
    output logic [COUNT_WIDTH-1:0] o_rise_total,
    output logic [COUNT_WIDTH-1:0] o_fall_total
);

    // Edge state
    logic [TIME_WIDTH-1:0]  r_last_rise;
    logic [TIME_WIDTH-1:0]  r_last_fall;
    logic                   r_seen_rise;
    logic                   r_seen_fall;
    logic [COUNT_WIDTH-1:0] r_rise_tot;
    logic [COUNT_WIDTH-1:0] r_fall_tot;

    // Pending edge being split into span operations
    logic                   r_pend_valid;
    logic                   r_pend_op_a;
    logic                   r_pend_op_b;
    logic                   r_pend_level;
    logic [TIME_WIDTH-1:0]  r_pend_ts;
    logic [TIME_WIDTH-1:0]  r_pend_rise_ref;
    logic [TIME_WIDTH-1:0]  r_pend_fall_ref;
    logic [COUNT_WIDTH-1:0] r_pend_rise_tot;
    logic [COUNT_WIDTH-1:0] r_pend_fall_tot;

    logic [COUNT_WIDTH-1:0] n_rise_tot;
    logic [COUNT_WIDTH-1:0] n_fall_tot;
    logic [TIME_WIDTH-1:0]  ref_time;
    logic [TIME_WIDTH-1:0]  diff;
    logic                   diff_hi_set;
    pts_pkg::t_op           cur_op;
    logic                   issue_fire;
    logic                   accept;

    // Build the current operation: low span first, then period or high span
    always_comb begin
        cur_op.kind = pts_pkg::KIND_NONE;
        cur_op.last = 1'b1;
        ref_time    = r_pend_rise_ref;
        if (r_pend_op_a) begin
            cur_op.kind = pts_pkg::KIND_LOW;
            cur_op.last = ~r_pend_op_b;
            ref_time    = r_pend_fall_ref;
        end else if (r_pend_op_b) begin
            cur_op.kind = r_pend_level ? pts_pkg::KIND_PERIOD : pts_pkg::KIND_HIGH;
        end
        diff = r_pend_ts - ref_time;
        if (cur_op.kind == pts_pkg::KIND_NONE) begin
            cur_op.span = '0;
        end else if (diff_hi_set) begin
            cur_op.span = pts_pkg::SPAN_MAX;
        end else begin
            cur_op.span = diff[pts_pkg::SPAN_W-1:0];
        end
    end

    // Saturate the modular delta to the span width
    generate
        if (TIME_WIDTH > pts_pkg::SPAN_W) begin : g_sat
            assign diff_hi_set = |diff[TIME_WIDTH-1:pts_pkg::SPAN_W];
        end else begin : g_nosat
            assign diff_hi_set = 1'b0;
        end
    endgenerate

    // Handshake: take a new edge as the last operation of the current one leaves
    assign issue_fire = r_pend_valid & i_credit_ok;
    assign o_stall    = r_pend_valid & ~(issue_fire & cur_op.last);
    assign accept     = i_valid & ~o_stall;

    // Saturating edge counters
    always_comb begin
        n_rise_tot = r_rise_tot;
        n_fall_tot = r_fall_tot;
        if (i_level) begin
            if (~&r_rise_tot) n_rise_tot = r_rise_tot + COUNT_WIDTH'(1);
        end else begin
            if (~&r_fall_tot) n_fall_tot = r_fall_tot + COUNT_WIDTH'(1);
        end
    end

    // Hold edge state and the pending operation flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_op_a  <= 1'b0;
            r_pend_op_b  <= 1'b0;
            r_seen_rise  <= 1'b0;
            r_seen_fall  <= 1'b0;
            r_last_rise  <= '0;
            r_last_fall  <= '0;
            r_rise_tot   <= '0;
            r_fall_tot   <= '0;
        end else begin
            if (accept) begin
                r_pend_valid <= 1'b1;
                r_pend_op_a  <= i_level & r_seen_fall;
                r_pend_op_b  <= r_seen_rise;
                r_rise_tot   <= n_rise_tot;
                r_fall_tot   <= n_fall_tot;
                if (i_level) begin
                    r_last_rise <= i_timestamp_us;
                    r_seen_rise <= 1'b1;
                end else begin
                    r_last_fall <= i_timestamp_us;
                    r_seen_fall <= 1'b1;
                end
            end else if (issue_fire) begin
                r_pend_op_a <= 1'b0;
                if (cur_op.last) r_pend_valid <= 1'b0;
            end
        end
    end

    // Capture the edge payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_level    <= i_level;
            r_pend_ts       <= i_timestamp_us;
            r_pend_rise_ref <= r_last_rise;
            r_pend_fall_ref <= r_last_fall;
            r_pend_rise_tot <= n_rise_tot;
            r_pend_fall_tot <= n_fall_tot;
        end
    end

    assign o_op_valid   = issue_fire;
    assign o_op         = cur_op;
    assign o_rise_total = r_pend_rise_tot;
    assign o_fall_total = r_pend_fall_tot;

`ifndef SYNTH
    a_low_only_on_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid && r_pend_op_a |-> r_pend_level)
        else $error("low span pending on a falling edge");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op_valid && o_op.kind == pts_pkg::KIND_NONE |-> o_op.last)
        else $error("empty result not marked last");
`endif

endmodule

// File: sv/pts_stat.sv
`timescale 1ns / 1ps
module pts_stat #(
    parameter int COUNT_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_op_valid,
    input  pts_pkg::t_op                i_op,
    input  logic [COUNT_WIDTH-1:0]      i_rise_total,
    input  logic [COUNT_WIDTH-1:0]      i_fall_total,
    output logic                        o_res_valid,
    output pts_pkg::t_kind              o_kind,
    output logic [pts_pkg::SPAN_W-1:0]  o_span,
    output logic [COUNT_WIDTH-1:0]      o_count,
    output logic [pts_pkg::SPAN_W-1:0]  o_span_min,
    output logic [pts_pkg::SPAN_W-1:0]  o_span_max,
    output logic [pts_pkg::SUM_W-1:0]   o_sum,
    output logic [COUNT_WIDTH-1:0]      o_rise_total,
    output logic [COUNT_WIDTH-1:0]      o_fall_total,
    output logic                        o_last
);

    typedef struct packed {
        logic [COUNT_WIDTH-1:0]     count;
        logic [pts_pkg::SUM_W-1:0]  sum;
        logic [pts_pkg::SPAN_W-1:0] span_min;
        logic [pts_pkg::SPAN_W-1:0] span_max;
    } t_entry;

    // Statistics memory, one entry per span class
    t_entry                    mem [pts_pkg::NUM_CLS];
    logic [pts_pkg::NUM_CLS-1:0] r_ent_vld;
    t_entry                    r_rd_q;

    // Update stage
    logic                      r_b_valid;
    pts_pkg::t_op              r_b_op;
    logic [pts_pkg::CLS_W-1:0] r_b_cls;
    logic                      r_b_ent_vld;
    logic [COUNT_WIDTH-1:0]    r_b_rtot;
    logic [COUNT_WIDTH-1:0]    r_b_ftot;

    // Last write, for forwarding
    logic                      r_wb_valid;
    logic [pts_pkg::CLS_W-1:0] r_wb_cls;
    t_entry                    r_wb_data;

    logic                      rd_en;
    logic [pts_pkg::CLS_W-1:0] rd_cls;
    logic                      b_write;
    logic                      fwd_hit;
    logic                      first;
    logic [pts_pkg::SUM_W:0]   sum_ext;
    t_entry                    cur;
    t_entry                    upd;

    assign rd_en  = i_op_valid & (i_op.kind != pts_pkg::KIND_NONE);
    assign rd_cls = pts_pkg::cls_of(i_op.kind);

    // Read the class entry as the operation enters
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_q      <= mem[rd_cls];
            r_b_ent_vld <= r_ent_vld[rd_cls];
        end
        r_b_op   <= i_op;
        r_b_cls  <= rd_cls;
        r_b_rtot <= i_rise_total;
        r_b_ftot <= i_fall_total;
    end

    assign b_write = r_b_valid & (r_b_op.kind != pts_pkg::KIND_NONE);
    assign fwd_hit = r_wb_valid & (r_wb_cls == r_b_cls);

    // Merge forwarded data, then update count, sum, min and max
    always_comb begin
        if (fwd_hit) begin
            cur = r_wb_data;
        end else if (r_b_ent_vld) begin
            cur = r_rd_q;
        end else begin
            cur = '0;
        end
        first     = (cur.count == '0);
        upd       = cur;
        if (~&cur.count) upd.count = cur.count + COUNT_WIDTH'(1);
        sum_ext   = {1'b0, cur.sum}
                  + {{(pts_pkg::SUM_W + 1 - pts_pkg::SPAN_W){1'b0}}, r_b_op.span};
        upd.sum   = sum_ext[pts_pkg::SUM_W] ? pts_pkg::SUM_MAX
                                            : sum_ext[pts_pkg::SUM_W-1:0];
        if (first || r_b_op.span < cur.span_min) upd.span_min = r_b_op.span;
        if (first || r_b_op.span > cur.span_max) upd.span_max = r_b_op.span;
    end

    // Write back and remember the write for the next operation
    always_ff @(posedge i_clk) begin
        if (b_write) mem[r_b_cls] <= upd;
        r_wb_cls  <= r_b_cls;
        r_wb_data <= upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_wb_valid <= 1'b0;
            r_ent_vld  <= '0;
        end else begin
            r_b_valid  <= i_op_valid;
            r_wb_valid <= b_write;
            if (b_write) r_ent_vld[r_b_cls] <= 1'b1;
        end
    end

    // Result beat; an empty result carries only the edge totals
    always_comb begin
        o_res_valid  = r_b_valid;
        o_kind       = r_b_op.kind;
        o_last       = r_b_op.last;
        o_rise_total = r_b_rtot;
        o_fall_total = r_b_ftot;
        if (r_b_op.kind == pts_pkg::KIND_NONE) begin
            o_span     = '0;
            o_count    = '0;
            o_span_min = '0;
            o_span_max = '0;
            o_sum      = '0;
        end else begin
            o_span     = r_b_op.span;
            o_count    = upd.count;
            o_span_min = upd.span_min;
            o_span_max = upd.span_max;
            o_sum      = upd.sum;
        end
    end

`ifndef SYNTH
    a_min_le_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_write |-> upd.span_min <= r_b_op.span && r_b_op.span <= upd.span_max)
        else $error("span outside class min/max after update");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_write |-> upd.count != '0)
        else $error("class count zero after a closed span");
`endif

endmodule

// File: sv/pts_fifo.sv
`timescale 1ns / 1ps
module pts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid & ~i_stall;
    assign o_data  = mem[r_rd_ptr];
    assign o_count = r_count;

    // Store a result beat
    always_ff @(posedge i_clk) begin
        if (i_push) mem[r_wr_ptr] <= i_data;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            if (pop)    r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            if (i_push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != CNT_W'(DEPTH) || pop)
        else $error("result buffer overflow");
`endif

endmodule

// File: sv/pulse_timing_statistics_unit.sv
`timescale 1ns / 1ps
// Pulse timing statistics.
// Input channel (i_valid / o_stall): one beat per line edge, carrying the new
// level (1 rising, 0 falling) and a free-running microsecond timestamp.
// Output channel (o_valid / i_stall): one beat per closed span with the
// updated count, sum, min and max of its class (period, high, low), plus the
// rise and fall totals. A rising edge gives up to two beats, low time first,
// then period. An edge closing nothing gives one beat of kind none. o_last
// marks the final beat of an edge.
// The first result beat of an edge passes the pending-edge registers, the
// update stage and the result buffer before it is offered at the output.
// A new edge is taken as the last span operation of the pending one issues;
// a rising edge closing both a low and a period span issues them in turn, and
// the statistics memory does one read-modify-write per span.
// A four-beat result buffer decouples the sides; when the receiver stalls,
// the buffer fills and the input is stalled once no room is left for spans
// already in flight.
// Reset clears edge state, counters and statistics; the result buffer empties.
module pulse_timing_statistics_unit #(
    parameter int TIME_WIDTH  = 48,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_level,
    input  logic [TIME_WIDTH-1:0]       i_timestamp_us,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_span_kind,
    output logic [pts_pkg::SPAN_W-1:0]  o_span_us,
    output logic [COUNT_WIDTH-1:0]      o_span_count,
    output logic [pts_pkg::SPAN_W-1:0]  o_span_min_us,
    output logic [pts_pkg::SPAN_W-1:0]  o_span_max_us,
    output logic [pts_pkg::SUM_W-1:0]   o_span_sum_us,
    output logic [COUNT_WIDTH-1:0]      o_rise_count,
    output logic [COUNT_WIDTH-1:0]      o_fall_count,
    output logic                        o_last
);

    localparam int RES_W = 2 + 4 * pts_pkg::SPAN_W - pts_pkg::SPAN_W
                         + pts_pkg::SUM_W + 3 * COUNT_WIDTH + 1;
    localparam int CNT_W = $clog2(pts_pkg::FIFO_DEPTH + 1);

    logic                       op_valid;
    pts_pkg::t_op               op;
    logic [COUNT_WIDTH-1:0]     op_rise_tot;
    logic [COUNT_WIDTH-1:0]     op_fall_tot;
    logic                       credit_ok;

    logic                       res_valid;
    pts_pkg::t_kind             res_kind;
    logic [pts_pkg::SPAN_W-1:0] res_span;
    logic [COUNT_WIDTH-1:0]     res_count;
    logic [pts_pkg::SPAN_W-1:0] res_min;
    logic [pts_pkg::SPAN_W-1:0] res_max;
    logic [pts_pkg::SUM_W-1:0]  res_sum;
    logic [COUNT_WIDTH-1:0]     res_rise;
    logic [COUNT_WIDTH-1:0]     res_fall;
    logic                       res_last;

    logic [RES_W-1:0]           fifo_wr_data;
    logic [RES_W-1:0]           fifo_rd_data;
    logic [CNT_W-1:0]           fifo_count;

    // Issue a span only if the buffer has room for it and the one in update
    assign credit_ok = (fifo_count + CNT_W'(res_valid)) < CNT_W'(pts_pkg::FIFO_DEPTH);

    pts_issue #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_issue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_level        (i_level),
        .i_timestamp_us (i_timestamp_us),
        .i_credit_ok    (credit_ok),
        .o_op_valid     (op_valid),
        .o_op           (op),
        .o_rise_total   (op_rise_tot),
        .o_fall_total   (op_fall_tot)
    );

    pts_stat #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_stat (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op_valid   (op_valid),
        .i_op         (op),
        .i_rise_total (op_rise_tot),
        .i_fall_total (op_fall_tot),
        .o_res_valid  (res_valid),
        .o_kind       (res_kind),
        .o_span       (res_span),
        .o_count      (res_count),
        .o_span_min   (res_min),
        .o_span_max   (res_max),
        .o_sum        (res_sum),
        .o_rise_total (res_rise),
        .o_fall_total (res_fall),
        .o_last       (res_last)
    );

    // Pack the result beat
    assign fifo_wr_data = {res_kind, res_span, res_count, res_min, res_max,
                           res_sum, res_rise, res_fall, res_last};

    pts_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pts_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (fifo_wr_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (fifo_rd_data),
        .o_count (fifo_count)
    );

    // Unpack onto the output ports
    assign {o_span_kind, o_span_us, o_span_count, o_span_min_us, o_span_max_us,
            o_span_sum_us, o_rise_count, o_fall_count, o_last} = fifo_rd_data;

endmodule

// File: test/tb_pulse_timing_statistics_unit.sv
`timescale 1ns / 1ps
module tb_pulse_timing_statistics_unit;

    localparam int TW = 48;
    // Counter width of the default build
    localparam int CW = 24;
    localparam int RANDOM_EDGES = 430;
    localparam int STUCK_LIMIT = 2000;
    localparam logic [TW-1:0] TS_MAX = '1;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // One result beat as seen on the output channel
    typedef struct packed {
        pts_pkg::t_kind             kind;
        logic [pts_pkg::SPAN_W-1:0] span;
        logic [CW-1:0]              count;
        logic [pts_pkg::SPAN_W-1:0] min_us;
        logic [pts_pkg::SPAN_W-1:0] max_us;
        logic [pts_pkg::SUM_W-1:0]  sum_us;
        logic [CW-1:0]              rises;
        logic [CW-1:0]              falls;
        logic                       last;
    } t_span_beat;

    // Edge timing state and per-class statistics; keeps the beats still owed
    class edge_stats_tracker;
        logic [TW-1:0]              rise_at;
        logic [TW-1:0]              fall_at;
        bit                         had_rise;
        bit                         had_fall;
        logic [CW-1:0]              rises;
        logic [CW-1:0]              falls;
        logic [CW-1:0]              n_span [1:3];
        logic [pts_pkg::SUM_W-1:0]  total [1:3];
        logic [pts_pkg::SPAN_W-1:0] shortest [1:3];
        logic [pts_pkg::SPAN_W-1:0] longest [1:3];
        t_span_beat                 awaited_beats [$];
        int                         errors;
        int                         edges_seen;
        int                         beats_seen;
        int                         beats_of_kind [0:3];
        bit                         rise_full;
        bit                         fall_full;
        bit                         sum_full;

        function new();
            rise_at = '0;
            fall_at = '0;
            had_rise = 1'b0;
            had_fall = 1'b0;
            rises = '0;
            falls = '0;
            foreach (n_span[c]) begin
                n_span[c] = '0;
                total[c] = '0;
                shortest[c] = '0;
                longest[c] = '0;
            end
            foreach (beats_of_kind[k]) beats_of_kind[k] = 0;
            errors = 0;
            edges_seen = 0;
            beats_seen = 0;
            rise_full = 1'b0;
            fall_full = 1'b0;
            sum_full = 1'b0;
        endfunction

        // Wrap the delta at the timestamp width, then clip it to 32 bits
        function logic [pts_pkg::SPAN_W-1:0] gap(input logic [TW-1:0] now_us,
                                                 input logic [TW-1:0] then_us);
            logic [TW-1:0] d;
            d = now_us - then_us;
            return (d > TW'(pts_pkg::SPAN_MAX)) ? pts_pkg::SPAN_MAX
                                                : d[pts_pkg::SPAN_W-1:0];
        endfunction

        function logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
            return (c == CNT_MAX) ? c : c + 1'b1;
        endfunction

        // Fold one span into its class and build the beat that reports it
        function t_span_beat close_span(input pts_pkg::t_kind k,
                                        input logic [pts_pkg::SPAN_W-1:0] s);
            int                      c;
            logic [pts_pkg::SUM_W:0] acc;
            t_span_beat              b;
            c = int'(k);
            acc = {1'b0, total[c]} + (pts_pkg::SUM_W + 1)'(s);
            if (n_span[c] == '0 || s < shortest[c]) shortest[c] = s;
            if (n_span[c] == '0 || s > longest[c]) longest[c] = s;
            n_span[c] = sat_inc(n_span[c]);
            total[c] = acc[pts_pkg::SUM_W] ? pts_pkg::SUM_MAX : acc[pts_pkg::SUM_W-1:0];
            if (total[c] == pts_pkg::SUM_MAX) sum_full = 1'b1;
            b = '0;
            b.kind = k;
            b.span = s;
            b.count = n_span[c];
            b.min_us = shortest[c];
            b.max_us = longest[c];
            b.sum_us = total[c];
            b.rises = rises;
            b.falls = falls;
            return b;
        endfunction

        // Accepted edge: advance the state and queue the beats it must cause
        function void take_edge(input logic lvl, input logic [TW-1:0] ts);
            t_span_beat fresh [$];
            t_span_beat b;
            edges_seen++;
            if (lvl) begin
                rises = sat_inc(rises);
                if (had_fall) fresh.push_back(close_span(pts_pkg::KIND_LOW, gap(ts, fall_at)));
                if (had_rise) fresh.push_back(close_span(pts_pkg::KIND_PERIOD, gap(ts, rise_at)));
                rise_at = ts;
                had_rise = 1'b1;
            end else begin
                falls = sat_inc(falls);
                if (had_rise) fresh.push_back(close_span(pts_pkg::KIND_HIGH, gap(ts, rise_at)));
                fall_at = ts;
                had_fall = 1'b1;
            end
            if (rises == CNT_MAX) rise_full = 1'b1;
            if (falls == CNT_MAX) fall_full = 1'b1;
            if (fresh.size() == 0) begin
                b = '0;
                b.kind = pts_pkg::KIND_NONE;
                b.rises = rises;
                b.falls = falls;
                fresh.push_back(b);
            end
            // Flag the final beat of this edge
            b = fresh.pop_back();
            b.last = 1'b1;
            fresh.push_back(b);
            foreach (fresh[i]) awaited_beats.push_back(fresh[i]);
        endfunction

        function void compare_field(input string field, input logic [63:0] want_v,
                                    input logic [63:0] got_v);
            if (want_v !== got_v) begin
                errors++;
                $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want_v, got_v);
            end
        endfunction

        // Accepted result: check it against the oldest beat still owed
        function void match_beat(input t_span_beat got);
            t_span_beat want;
            beats_seen++;
            if (awaited_beats.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result beat, kind %0d span 0x%0h",
                         $time, got.kind, got.span);
                return;
            end
            want = awaited_beats.pop_front();
            beats_of_kind[int'(want.kind)]++;
            compare_field("span_kind", 64'(want.kind), 64'(got.kind));
            compare_field("span_us", 64'(want.span), 64'(got.span));
            compare_field("span_count", 64'(want.count), 64'(got.count));
            compare_field("span_min_us", 64'(want.min_us), 64'(got.min_us));
            compare_field("span_max_us", 64'(want.max_us), 64'(got.max_us));
            compare_field("span_sum_us", 64'(want.sum_us), 64'(got.sum_us));
            compare_field("rise_count", 64'(want.rises), 64'(got.rises));
            compare_field("fall_count", 64'(want.falls), 64'(got.falls));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_level = 1'b0;
    logic [TW-1:0]              i_timestamp_us = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [1:0]                 o_span_kind;
    logic [pts_pkg::SPAN_W-1:0] o_span_us;
    logic [CW-1:0]              o_span_count;
    logic [pts_pkg::SPAN_W-1:0] o_span_min_us;
    logic [pts_pkg::SPAN_W-1:0] o_span_max_us;
    logic [pts_pkg::SUM_W-1:0]  o_span_sum_us;
    logic [CW-1:0]              o_rise_count;
    logic [CW-1:0]              o_fall_count;
    logic                       o_last;

    bit                quiet = 1'b0;
    int                stuck_cycles = 0;
    edge_stats_tracker stats;

    pulse_timing_statistics_unit #(
        .TIME_WIDTH  (TW),
        .COUNT_WIDTH (CW)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_level        (i_level),
        .i_timestamp_us (i_timestamp_us),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_span_kind    (o_span_kind),
        .o_span_us      (o_span_us),
        .o_span_count   (o_span_count),
        .o_span_min_us  (o_span_min_us),
        .o_span_max_us  (o_span_max_us),
        .o_span_sum_us  (o_span_sum_us),
        .o_rise_count   (o_rise_count),
        .o_fall_count   (o_fall_count),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side at random, except during the quiet stretch
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 27);
    end

    // Sample both channels at the edge; count cycles where nothing moves
    always @(posedge i_clk) begin : monitor
        t_span_beat got;
        if (i_rst_n) begin
            if (i_valid && !o_stall) stats.take_edge(i_level, i_timestamp_us);
            if (o_valid && !i_stall) begin
                got.kind = pts_pkg::t_kind'(o_span_kind);
                got.span = o_span_us;
                got.count = o_span_count;
                got.min_us = o_span_min_us;
                got.max_us = o_span_max_us;
                got.sum_us = o_span_sum_us;
                got.rises = o_rise_count;
                got.falls = o_fall_count;
                got.last = o_last;
                stats.match_beat(got);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t ns: no beat moved for %0d cycles", $time, STUCK_LIMIT);
                $display("pulse_timing_statistics_unit regression: fail");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    // Offer one edge beat, with random idle cycles ahead of it; hold until taken
    task automatic send_edge(input logic lvl, input logic [TW-1:0] ts);
        while (!quiet && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_level <= lvl;
        i_timestamp_us <= ts;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [TW-1:0] clock_us;
        logic [TW-1:0] ts;
        logic [TW-1:0] step;
        logic          lvl;
        logic          level_now;
        int            pick;

        stats = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Falls before any rise close nothing
        send_edge(1'b0, '0);
        send_edge(1'b0, 48'd5);
        // First low span, then a zero-length period
        send_edge(1'b1, 48'd10);
        send_edge(1'b1, 48'd10);
        // Largest timestamp, then a wrap through zero
        send_edge(1'b0, TS_MAX);
        send_edge(1'b1, 48'd3);
        // Spans right at, above and below the 32-bit ceiling
        send_edge(1'b0, 48'h0_0001_0000_0002);
        send_edge(1'b1, 48'h0_0001_0000_0003);
        send_edge(1'b0, 48'h0_0002_0000_0001);
        send_edge(1'b1, 48'h0_0002_0000_0001);
        // Short spans pull the minimums down
        send_edge(1'b0, 48'h0_0002_0000_0008);
        send_edge(1'b1, 48'h0_0002_0000_0010);
        // Alternating bit patterns, timestamp going backwards
        send_edge(1'b1, 48'hAAAA_AAAA_AAAA);
        send_edge(1'b0, 48'h5555_5555_5555);
        send_edge(1'b0, 48'h5555_5555_5556);
        send_edge(1'b1, 48'h5555_5555_5600);
        send_edge(1'b0, 48'h5555_5555_5601);
        send_edge(1'b1, TS_MAX);
        send_edge(1'b1, '0);
        send_edge(1'b0, 48'd2);

        // Mostly alternating edges with long gaps; some repeats and noise
        level_now = 1'b0;
        clock_us = TS_MAX - TW'({12'($urandom_range(0, 4095)), 32'h0});
        for (int i = 0; i < RANDOM_EDGES; i++) begin
            quiet = (i >= 200 && i < 320);
            lvl = ($urandom_range(99) < 80) ? !level_now : 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 15) begin
                step = TW'($urandom_range(1, 2000));
            end else if (pick < 25) begin
                step = TW'(pts_pkg::SPAN_MAX) - 48'd2 + TW'($urandom_range(0, 4));
            end else begin
                step = {12'h0, 4'($urandom_range(1, 15)), 32'($urandom)};
            end
            clock_us = clock_us + step;
            ts = ($urandom_range(99) < 8) ? {16'($urandom), 32'($urandom)} : clock_us;
            send_edge(lvl, ts);
            level_now = lvl;
        end
        quiet = 1'b0;

        // Drop valid, drain what is owed, then let the pipeline settle
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (stats.awaited_beats.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("covered %0d edges, %0d result beats (none %0d, period %0d, high %0d, low %0d)",
                 stats.edges_seen, stats.beats_seen,
                 stats.beats_of_kind[pts_pkg::KIND_NONE],
                 stats.beats_of_kind[pts_pkg::KIND_PERIOD],
                 stats.beats_of_kind[pts_pkg::KIND_HIGH],
                 stats.beats_of_kind[pts_pkg::KIND_LOW]);
        $display("ceilings reached: rise count %0d, fall count %0d, class sum %0d; %0d errors",
                 stats.rise_full, stats.fall_full, stats.sum_full, stats.errors);
        if (stats.errors == 0) begin
            $display("pulse_timing_statistics_unit regression: pass");
        end else begin
            $display("pulse_timing_statistics_unit regression: fail");
        end
        $finish;
    end

endmodule
